>>> rtl/iau_pkg.sv
package iau_pkg;

  // Field and arithmetic widths.
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int WIDE_W    = NUM_W + 2;
  localparam int SQ_STEPS  = NUM_W / 2;
  localparam int SQ_REM_W  = SQ_STEPS + 2;
  localparam int DIV_STEPS = NUM_W;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // Saturation range, in the wide domain and at field width.
  localparam wide_t RNG_MAX = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam wide_t RNG_MIN = {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Operation codes; the first ten match the mode field.
  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_MIN    = 4'd4,
    OP_MAX    = 4'd5,
    OP_NEG    = 4'd6,
    OP_ABS    = 4'd7,
    OP_SQUARE = 4'd8,
    OP_SQRT   = 4'd9,
    OP_NONE   = 4'd10
  } op_t;

  localparam logic [3:0] MODE_LAST = 4'd9;

  // A classified item as it waits in the queue.
  typedef struct packed {
    op_t   op;
    logic  div_zero;
    data_t a_lower;
    data_t a_upper;
    data_t b_lower;
    data_t b_upper;
  } item_t;

  function automatic wide_t min_w(input wide_t x, input wide_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic wide_t max_w(input wide_t x, input wide_t y);
    return (x > y) ? x : y;
  endfunction

endpackage

>>> rtl/iau_if.sv
// Request channel: mode and two intervals.
interface iau_req_if;
  logic                 valid;
  logic                 ready;
  logic [3:0]           mode;
  iau_pkg::data_t       a_lower;
  iau_pkg::data_t       a_upper;
  iau_pkg::data_t       b_lower;
  iau_pkg::data_t       b_upper;

  modport source (output valid, mode, a_lower, a_upper, b_lower, b_upper, input ready);
  modport sink (input valid, mode, a_lower, a_upper, b_lower, b_upper, output ready);
endinterface

// Response channel: result interval and flags.
interface iau_rsp_if;
  logic           valid;
  logic           ready;
  iau_pkg::data_t res_lower;
  iau_pkg::data_t res_upper;
  logic           unbounded;
  logic           saturated;

  modport source (output valid, res_lower, res_upper, unbounded, saturated, input ready);
  modport sink (input valid, res_lower, res_upper, unbounded, saturated, output ready);
endinterface

>>> rtl/iau_front.sv
module iau_front (
  iau_req_if.sink         req,
  input  logic            q_ready,
  output logic            push,
  output iau_pkg::item_t  item
);

  // The queue decides whether an item can be taken.
  assign req.ready = q_ready;
  assign push      = req.valid && q_ready;

  // Classify the mode and spot a divisor interval that holds zero.
  always_comb begin
    item.op       = (req.mode <= iau_pkg::MODE_LAST) ? iau_pkg::op_t'(req.mode)
                                                     : iau_pkg::OP_NONE;
    item.div_zero = (req.b_lower <= 0 && req.b_upper >= 0) ||
                    req.b_lower == 0 || req.b_upper == 0;
    item.a_lower  = req.a_lower;
    item.a_upper  = req.a_upper;
    item.b_lower  = req.b_lower;
    item.b_upper  = req.b_upper;
  end

endmodule

>>> rtl/iau_queue.sv
module iau_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  iau_pkg::item_t  push_item,
  input  logic            pop,
  output logic            ready,
  output logic            valid,
  output iau_pkg::item_t  head
);

  iau_pkg::item_t mem [2];
  logic [1:0]     cnt;
  logic           wp;
  logic           rp;

  assign ready = (cnt != 2'd2);
  assign valid = (cnt != 2'd0);
  assign head  = mem[rp];

  // Two-entry circular buffer between the front and the back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem[wp] <= push_item;
    end
  end

endmodule

>>> rtl/iau_back.sv
module iau_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  iau_pkg::item_t  q_item,
  output logic            q_pop,
  iau_rsp_if.source       rsp
);

  typedef struct packed {
    iau_pkg::op_t                                op;
    logic                                        unb;
    logic                                        sq_cross;
    iau_pkg::wide_t                              lo;
    iau_pkg::wide_t                              hi;
    logic [3:0][iau_pkg::PROD_W-1:0]             p;
    logic [1:0][iau_pkg::NUM_W-1:0]              nmag;
    logic [1:0][iau_pkg::DATA_W-1:0]             dmag;
    logic [1:0]                                  sa;
    logic [1:0]                                  sb;
    logic [1:0][iau_pkg::NUM_W-1:0]              srad;
  } h1_t;

  typedef struct packed {
    iau_pkg::op_t                                op;
    logic                                        unb;
    iau_pkg::wide_t                              lo;
    iau_pkg::wide_t                              hi;
    logic [3:0]                                  neg;
    logic [3:0][iau_pkg::DATA_W-1:0]             dvs;
    logic [3:0][iau_pkg::DATA_W-1:0]             rem;
    logic [3:0][iau_pkg::NUM_W-1:0]              nq;
    logic [1:0][iau_pkg::SQ_REM_W-1:0]           srem;
    logic [1:0][iau_pkg::SQ_STEPS-1:0]           root;
    logic [1:0][iau_pkg::NUM_W-1:0]              sv;
  } chain_t;

  typedef struct packed {
    iau_pkg::op_t                                op;
    logic                                        unb;
    iau_pkg::wide_t                              lo;
    iau_pkg::wide_t                              hi;
    logic [3:0][iau_pkg::WIDE_W-1:0]             q;
    logic [1:0][iau_pkg::SQ_STEPS-1:0]           root;
  } t1_t;

  typedef struct packed {
    logic           unb;
    iau_pkg::wide_t lo;
    iau_pkg::wide_t hi;
  } t2_t;

  localparam int NS = iau_pkg::DIV_STEPS;

  logic                 en;
  logic                 h1_vld;
  h1_t                  h1;
  h1_t                  h1_next;
  logic [NS:0]          vld;
  chain_t               dat [NS+1];
  chain_t               dat0_next;
  logic                 t1_vld;
  t1_t                  t1;
  t1_t                  t1_next;
  logic                 t2_vld;
  t2_t                  t2;
  t2_t                  t2_next;
  logic                 out_vld;
  iau_pkg::data_t       out_lo;
  iau_pkg::data_t       out_hi;
  logic                 out_unb;
  logic                 out_sat;
  iau_pkg::data_t       lo_clip;
  iau_pkg::data_t       hi_clip;
  logic                 sat_next;

  // The whole pipeline moves when the output register can take a result.
  assign en    = !out_vld || rsp.ready;
  assign q_pop = en && q_valid;

  // Stage one: simple operations, the four multipliers and setup of the dividers and square roots.
  always_comb begin
    iau_pkg::wide_t al, au, bl, bu, absl, absu;
    iau_pkg::data_t mx [4];
    iau_pkg::data_t my [4];
    iau_pkg::data_t av [2];
    iau_pkg::data_t bv [2];
    logic signed [iau_pkg::PROD_W-1:0] prod;
    al   = iau_pkg::wide_t'(q_item.a_lower);
    au   = iau_pkg::wide_t'(q_item.a_upper);
    bl   = iau_pkg::wide_t'(q_item.b_lower);
    bu   = iau_pkg::wide_t'(q_item.b_upper);
    absl = (al < 0) ? -al : al;
    absu = (au < 0) ? -au : au;
    av[0] = q_item.a_lower;
    av[1] = q_item.a_upper;
    bv[0] = q_item.b_lower;
    bv[1] = q_item.b_upper;

    h1_next          = '0;
    h1_next.op       = q_item.op;
    h1_next.unb      = (q_item.op == iau_pkg::OP_DIV) && q_item.div_zero;
    h1_next.sq_cross = (au > 0) && (al < 0);

    unique case (q_item.op)
      iau_pkg::OP_ADD: begin
        h1_next.lo = al + bl;
        h1_next.hi = au + bu;
      end
      iau_pkg::OP_SUB: begin
        h1_next.lo = al - bu;
        h1_next.hi = au - bl;
      end
      iau_pkg::OP_MIN: begin
        h1_next.lo = iau_pkg::min_w(al, bl);
        h1_next.hi = iau_pkg::min_w(au, bu);
      end
      iau_pkg::OP_MAX: begin
        h1_next.lo = iau_pkg::max_w(al, bl);
        h1_next.hi = iau_pkg::max_w(au, bu);
      end
      iau_pkg::OP_NEG: begin
        h1_next.lo = -au;
        h1_next.hi = -al;
      end
      iau_pkg::OP_ABS: begin
        h1_next.lo = (al < 0) ? '0 : iau_pkg::min_w(absl, absu);
        h1_next.hi = iau_pkg::max_w(absl, absu);
      end
      iau_pkg::OP_DIV: begin
        h1_next.lo = iau_pkg::RNG_MIN;
        h1_next.hi = iau_pkg::RNG_MAX;
      end
      default: begin
        h1_next.lo = '0;
        h1_next.hi = '0;
      end
    endcase

    // Square reuses the multipliers with both operands from A.
    if (q_item.op == iau_pkg::OP_SQUARE) begin
      mx[0] = q_item.a_upper; my[0] = q_item.a_upper;
      mx[1] = q_item.a_lower; my[1] = q_item.a_lower;
      mx[2] = q_item.a_upper; my[2] = q_item.a_upper;
      mx[3] = q_item.a_lower; my[3] = q_item.a_lower;
    end else begin
      mx[0] = q_item.a_lower; my[0] = q_item.b_lower;
      mx[1] = q_item.a_lower; my[1] = q_item.b_upper;
      mx[2] = q_item.a_upper; my[2] = q_item.b_lower;
      mx[3] = q_item.a_upper; my[3] = q_item.b_upper;
    end
    for (int u = 0; u < 4; u++) begin
      prod         = mx[u] * my[u];
      h1_next.p[u] = prod;
    end

    // Magnitudes and signs for the dividers, radicands for the square roots.
    for (int i = 0; i < 2; i++) begin
      h1_next.sa[i]   = av[i][iau_pkg::DATA_W-1];
      h1_next.sb[i]   = bv[i][iau_pkg::DATA_W-1];
      h1_next.nmag[i] = iau_pkg::NUM_W'(av[i][iau_pkg::DATA_W-1] ?
                        iau_pkg::DATA_W'(-av[i]) : av[i]) << iau_pkg::FRAC_BITS;
      h1_next.dmag[i] = bv[i][iau_pkg::DATA_W-1] ? iau_pkg::DATA_W'(-bv[i]) : bv[i];
      h1_next.srad[i] = (av[i] > 0) ?
                        (iau_pkg::NUM_W'(av[i]) << iau_pkg::FRAC_BITS) : '0;
    end
  end

  // Stage two: bounds of products, and loading of the digit units.
  always_comb begin
    iau_pkg::wide_t c [4];
    for (int u = 0; u < 4; u++) begin
      c[u] = iau_pkg::wide_t'($signed(h1.p[u]) >>> iau_pkg::FRAC_BITS);
    end
    dat0_next    = '0;
    dat0_next.op  = h1.op;
    dat0_next.unb = h1.unb;
    if (h1.op == iau_pkg::OP_MUL || h1.op == iau_pkg::OP_SQUARE) begin
      dat0_next.lo = iau_pkg::min_w(iau_pkg::min_w(c[0], c[1]), iau_pkg::min_w(c[2], c[3]));
      dat0_next.hi = iau_pkg::max_w(iau_pkg::max_w(c[0], c[1]), iau_pkg::max_w(c[2], c[3]));
      if (h1.op == iau_pkg::OP_SQUARE && h1.sq_cross) begin
        dat0_next.lo = '0;
      end
    end else begin
      dat0_next.lo = h1.lo;
      dat0_next.hi = h1.hi;
    end
    for (int u = 0; u < 4; u++) begin
      dat0_next.nq[u]  = h1.nmag[u >> 1];
      dat0_next.dvs[u] = h1.dmag[u & 1];
      dat0_next.neg[u] = h1.sa[u >> 1] ^ h1.sb[u & 1];
    end
    dat0_next.sv = h1.srad;
  end

  // Front stages of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      h1_vld <= 1'b0;
      vld[0] <= 1'b0;
    end else if (en) begin
      h1_vld <= q_valid;
      vld[0] <= h1_vld;
    end
    if (en) begin
      h1     <= h1_next;
      dat[0] <= dat0_next;
    end
  end

  // Digit stages: one quotient bit per divider, and in the early
  // stages one root bit per square root.
  for (genvar k = 0; k < NS; k++) begin : g_step
    chain_t nxt;

    always_comb begin
      logic [iau_pkg::DATA_W:0]     cur;
      logic                         ge;
      logic [iau_pkg::SQ_REM_W+1:0] scur;
      logic [iau_pkg::SQ_REM_W+1:0] trial;
      logic                         sge;
      nxt = dat[k];
      for (int u = 0; u < 4; u++) begin
        cur  = {dat[k].rem[u], dat[k].nq[u][iau_pkg::NUM_W-1]};
        ge   = cur >= {1'b0, dat[k].dvs[u]};
        nxt.rem[u] = ge ? iau_pkg::DATA_W'(cur - {1'b0, dat[k].dvs[u]})
                        : cur[iau_pkg::DATA_W-1:0];
        nxt.nq[u]  = {dat[k].nq[u][iau_pkg::NUM_W-2:0], ge};
      end
      for (int i = 0; i < 2; i++) begin
        scur  = {dat[k].srem[i], dat[k].sv[i][iau_pkg::NUM_W-1 -: 2]};
        trial = (iau_pkg::SQ_REM_W+2)'({dat[k].root[i], 2'b01});
        sge   = scur >= trial;
        if (k < iau_pkg::SQ_STEPS) begin
          nxt.srem[i] = sge ? iau_pkg::SQ_REM_W'(scur - trial)
                            : iau_pkg::SQ_REM_W'(scur);
          nxt.root[i] = {dat[k].root[i][iau_pkg::SQ_STEPS-2:0], sge};
          nxt.sv[i]   = dat[k].sv[i] << 2;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        dat[k+1] <= nxt;
      end
    end
  end

  // Signed quotients with rounding toward minus infinity.
  always_comb begin
    iau_pkg::wide_t mag;
    t1_next      = '0;
    t1_next.op   = dat[NS].op;
    t1_next.unb  = dat[NS].unb;
    t1_next.lo   = dat[NS].lo;
    t1_next.hi   = dat[NS].hi;
    t1_next.root = dat[NS].root;
    for (int u = 0; u < 4; u++) begin
      mag = iau_pkg::wide_t'(dat[NS].nq[u]);
      t1_next.q[u] = dat[NS].neg[u] ?
                     (-mag - iau_pkg::wide_t'(dat[NS].rem[u] != '0)) : mag;
    end
  end

  // Final bounds per operation.
  always_comb begin
    t2_next     = '0;
    t2_next.unb = t1.unb;
    if (t1.op == iau_pkg::OP_DIV && !t1.unb) begin
      t2_next.lo = iau_pkg::min_w(iau_pkg::min_w(t1.q[0], t1.q[1]),
                                  iau_pkg::min_w(t1.q[2], t1.q[3]));
      t2_next.hi = iau_pkg::max_w(iau_pkg::max_w(t1.q[0], t1.q[1]),
                                  iau_pkg::max_w(t1.q[2], t1.q[3]));
    end else if (t1.op == iau_pkg::OP_SQRT) begin
      t2_next.lo = iau_pkg::wide_t'(t1.root[0]);
      t2_next.hi = iau_pkg::wide_t'(t1.root[1]);
    end else begin
      t2_next.lo = t1.lo;
      t2_next.hi = t1.hi;
    end
  end

  // Saturation to the field range.
  always_comb begin
    logic sl, sh;
    sl = (t2.lo > iau_pkg::RNG_MAX) || (t2.lo < iau_pkg::RNG_MIN);
    sh = (t2.hi > iau_pkg::RNG_MAX) || (t2.hi < iau_pkg::RNG_MIN);
    lo_clip  = (t2.lo > iau_pkg::RNG_MAX) ? iau_pkg::DATA_MAX :
               (t2.lo < iau_pkg::RNG_MIN) ? iau_pkg::DATA_MIN :
               iau_pkg::data_t'(t2.lo);
    hi_clip  = (t2.hi > iau_pkg::RNG_MAX) ? iau_pkg::DATA_MAX :
               (t2.hi < iau_pkg::RNG_MIN) ? iau_pkg::DATA_MIN :
               iau_pkg::data_t'(t2.hi);
    sat_next = sl || sh;
  end

  // Back stages and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_vld  <= 1'b0;
      t2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      t1_vld  <= vld[NS];
      t2_vld  <= t1_vld;
      out_vld <= t2_vld;
    end
    if (en) begin
      t1      <= t1_next;
      t2      <= t2_next;
      out_lo  <= lo_clip;
      out_hi  <= hi_clip;
      out_unb <= t2.unb;
      out_sat <= sat_next;
    end
  end

  assign rsp.valid     = out_vld;
  assign rsp.res_lower = out_lo;
  assign rsp.res_upper = out_hi;
  assign rsp.unbounded = out_unb;
  assign rsp.saturated = out_sat;

endmodule

>>> rtl/interval_arithmetic_unit.sv
// Interval arithmetic unit, signed Q16.16.
// The req channel carries a mode and two intervals A and B; the rsp channel
// returns one result interval per item with an unbounded and a saturated flag.
// Both channels use valid/ready; an item moves when both are high.
// A front stage classifies each item and writes it into a two-entry queue;
// the back part is a fixed pipeline that pops one item per cycle while rsp
// is not stalled. Throughput is then one item per cycle.
// The depth is set by the four restoring dividers, which produce one
// quotient bit per stage over 48 stages; the two square roots finish their
// 24 root bits within the same stages.
// When rsp.ready is low with a result waiting, the back pipeline holds; the
// queue keeps taking items until its two entries are full, then req.ready
// drops. Synchronous reset empties the queue and the pipeline; no result is
// shown until a new item arrives.
module interval_arithmetic_unit (
  input  logic      clk,
  input  logic      rst,
  iau_req_if.sink   req,
  iau_rsp_if.source rsp
);

  logic           q_ready;
  logic           q_valid;
  logic           q_pop;
  logic           push;
  iau_pkg::item_t item;
  iau_pkg::item_t head;

  iau_front u_front (
    .req     (req),
    .q_ready (q_ready),
    .push    (push),
    .item    (item)
  );

  iau_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (item),
    .pop       (q_pop),
    .ready     (q_ready),
    .valid     (q_valid),
    .head      (head)
  );

  iau_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (head),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

  // An unbounded result is always the full range and never flagged clipped.
  a_unb_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.unbounded |->
      rsp.res_lower == iau_pkg::DATA_MIN && rsp.res_upper == iau_pkg::DATA_MAX &&
      !rsp.saturated)
    else $error("unbounded result is not the full range");

  // A clipped result has at least one bound at a range limit.
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.saturated |->
      rsp.res_lower == iau_pkg::DATA_MIN || rsp.res_lower == iau_pkg::DATA_MAX ||
      rsp.res_upper == iau_pkg::DATA_MIN || rsp.res_upper == iau_pkg::DATA_MAX)
    else $error("saturated flag without a bound at a limit");

  // A full queue always has an item for the back part.
  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    !q_ready |-> q_valid)
    else $error("queue full but empty");

  // The queue is popped only when it holds an item.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

>>> dv/interval_arithmetic_unit_tb.sv
module interval_arithmetic_unit_tb;

  // Result of one interval operation as seen on the rsp channel.
  typedef struct {
    iau_pkg::data_t lo;
    iau_pkg::data_t hi;
    logic           unb;
    logic           sat;
  } iv_result_t;

  // One row of stimulus; typed rows carry their expected result.
  typedef struct {
    logic [3:0]     mode;
    iau_pkg::data_t al;
    iau_pkg::data_t au;
    iau_pkg::data_t bl;
    iau_pkg::data_t bu;
    bit             typed;
    iv_result_t     want;
  } iv_item_t;

  localparam logic [3:0] MODE_TOP   = 4'hF;
  localparam int         NUM_RANDOM = 1000;
  localparam int         DRAIN_CYC  = 80;
  localparam int         CYCLE_CAP  = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  iau_req_if req_ch ();
  iau_rsp_if rsp_ch ();

  interval_arithmetic_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  iv_item_t   stim_list[$];
  iv_result_t pending_results[$];
  int         error_count = 0;
  int         result_count = 0;
  int         mode_hits[16];

  // Clip a wide value to the field range and note any clipping.
  function automatic longint clip32(input longint v, inout bit flag);
    if (v > longint'(iau_pkg::DATA_MAX)) begin
      flag = 1'b1;
      return longint'(iau_pkg::DATA_MAX);
    end
    if (v < longint'(iau_pkg::DATA_MIN)) begin
      flag = 1'b1;
      return longint'(iau_pkg::DATA_MIN);
    end
    return v;
  endfunction

  // Fixed point product, rounded toward minus infinity.
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> iau_pkg::FRAC_BITS;
  endfunction

  // Fixed point quotient, rounded toward minus infinity.
  function automatic longint fx_div(input longint a, input longint b);
    longint n;
    longint q;
    n = a * (longint'(1) << iau_pkg::FRAC_BITS);
    q = n / b;
    if ((n % b) != 0 && ((n < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  // Floor of the square root of x scaled by the fraction bits.
  function automatic longint fx_sqrt(input longint x);
    longint v;
    longint r;
    longint t;
    if (x <= 0) return 0;
    v = x << iau_pkg::FRAC_BITS;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint abs_l(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint min_l(input longint x, input longint y);
    return (x < y) ? x : y;
  endfunction

  function automatic longint max_l(input longint x, input longint y);
    return (x > y) ? x : y;
  endfunction

  // Expected result interval for one request item.
  function automatic iv_result_t predict_interval(input iv_item_t it);
    iv_result_t r;
    longint al, au, bl, bu, lo, hi, c1, c2, c3, c4;
    bit clipped;
    bit unb;
    al = it.al;
    au = it.au;
    bl = it.bl;
    bu = it.bu;
    lo = 0;
    hi = 0;
    clipped = 1'b0;
    unb = 1'b0;
    case (iau_pkg::op_t'(it.mode))
      iau_pkg::OP_ADD: begin
        lo = al + bl;
        hi = au + bu;
      end
      iau_pkg::OP_SUB: begin
        lo = al - bu;
        hi = au - bl;
      end
      iau_pkg::OP_MUL: begin
        c1 = fx_mul(al, bl);
        c2 = fx_mul(al, bu);
        c3 = fx_mul(au, bl);
        c4 = fx_mul(au, bu);
        lo = min_l(min_l(c1, c2), min_l(c3, c4));
        hi = max_l(max_l(c1, c2), max_l(c3, c4));
      end
      iau_pkg::OP_DIV: begin
        if ((bl <= 0 && bu >= 0) || bl == 0 || bu == 0) begin
          unb = 1'b1;
          lo = longint'(iau_pkg::DATA_MIN);
          hi = longint'(iau_pkg::DATA_MAX);
        end else begin
          c1 = fx_div(al, bl);
          c2 = fx_div(al, bu);
          c3 = fx_div(au, bl);
          c4 = fx_div(au, bu);
          lo = min_l(min_l(c1, c2), min_l(c3, c4));
          hi = max_l(max_l(c1, c2), max_l(c3, c4));
        end
      end
      iau_pkg::OP_MIN: begin
        lo = min_l(al, bl);
        hi = min_l(au, bu);
      end
      iau_pkg::OP_MAX: begin
        lo = max_l(al, bl);
        hi = max_l(au, bu);
      end
      iau_pkg::OP_NEG: begin
        lo = -au;
        hi = -al;
      end
      iau_pkg::OP_ABS: begin
        lo = (al < 0) ? 0 : min_l(abs_l(al), abs_l(au));
        hi = max_l(abs_l(al), abs_l(au));
      end
      iau_pkg::OP_SQUARE: begin
        c1 = fx_mul(au, au);
        c2 = fx_mul(al, al);
        lo = (au > 0 && al < 0) ? 0 : min_l(c1, c2);
        hi = max_l(c1, c2);
      end
      iau_pkg::OP_SQRT: begin
        lo = fx_sqrt(al);
        hi = fx_sqrt(au);
      end
      default: begin
      end
    endcase
    lo = clip32(lo, clipped);
    hi = clip32(hi, clipped);
    r.lo = iau_pkg::data_t'(lo);
    r.hi = iau_pkg::data_t'(hi);
    r.unb = unb;
    r.sat = clipped;
    return r;
  endfunction

  task automatic add_row(input logic [3:0] mode, input iau_pkg::data_t al,
                         input iau_pkg::data_t au, input iau_pkg::data_t bl,
                         input iau_pkg::data_t bu, input bit typed,
                         input iau_pkg::data_t wlo, input iau_pkg::data_t whi,
                         input logic wunb, input logic wsat);
    iv_item_t it;
    it.mode = mode;
    it.al = al;
    it.au = au;
    it.bl = bl;
    it.bu = bu;
    it.typed = typed;
    it.want.lo = wlo;
    it.want.hi = whi;
    it.want.unb = wunb;
    it.want.sat = wsat;
    stim_list.push_back(it);
  endtask

  // A bound drawn from a mix of scales, with the extremes well represented.
  function automatic iau_pkg::data_t rand_bound();
    case ($urandom_range(0, 5))
      0: return iau_pkg::data_t'($urandom());
      1: return iau_pkg::data_t'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      2: begin
        case ($urandom_range(0, 3))
          0: return iau_pkg::DATA_MAX;
          1: return iau_pkg::DATA_MIN;
          2: return '0;
          default: return iau_pkg::data_t'(32'sh0001_0000);
        endcase
      end
      3: return iau_pkg::data_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      default: return iau_pkg::data_t'(int'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    error_count++;
    $display("mismatch on result %0d: %s got %0d expected %0d", result_count, field, got, want);
  endtask

  // Build the directed table and the random items.
  initial begin
    iv_item_t it;
    iau_pkg::data_t t;
    // Small cases of add, sub, mul, div, min, max and neg, checked against the predictor.
    add_row(iau_pkg::OP_ADD, 32'sh0001_0000, 32'sh0002_0000, -32'sh0000_8000, 32'sh0000_8000,
            0, '0, '0, 0, 0);
    add_row(iau_pkg::OP_SUB, -32'sh0003_0000, 32'sh0001_0000, 32'sh0000_4000, 32'sh0002_0000,
            0, '0, '0, 0, 0);
    add_row(iau_pkg::OP_MUL, -32'sh0002_0000, 32'sh0003_8000, -32'sh0001_0000, 32'sh0000_0003,
            0, '0, '0, 0, 0);
    add_row(iau_pkg::OP_DIV, 32'sh0001_0000, 32'sh0007_0000, 32'sh0003_0000, 32'sh0005_0000,
            0, '0, '0, 0, 0);
    add_row(iau_pkg::OP_DIV, -32'sh0001_0001, 32'sh0000_0001, -32'sh0000_0003,
            -32'sh0000_0001, 0, '0, '0, 0, 0);
    add_row(iau_pkg::OP_MIN, 32'sh0001_0000, 32'sh0004_0000, -32'sh0001_0000, 32'sh0009_0000,
            0, '0, '0, 0, 0);
    add_row(iau_pkg::OP_MAX, 32'sh0001_0000, 32'sh0004_0000, -32'sh0001_0000, 32'sh0009_0000,
            0, '0, '0, 0, 0);
    add_row(iau_pkg::OP_NEG, -32'sh0001_0000, 32'sh0002_0000, '0, '0, 0, '0, '0, 0, 0);
    // Abs with a negative lower bound gives a lower bound of zero.
    add_row(iau_pkg::OP_ABS, -32'sh0005_0000, 32'sh0002_0000, '0, '0,
            1, '0, 32'sh0005_0000, 0, 0);
    add_row(iau_pkg::OP_ABS, 32'sh0002_0000, 32'sh0005_0000, '0, '0,
            1, 32'sh0002_0000, 32'sh0005_0000, 0, 0);
    // Square across zero also gives a lower bound of zero.
    add_row(iau_pkg::OP_SQUARE, -32'sh0002_0000, 32'sh0003_0000, '0, '0,
            1, '0, 32'sh0009_0000, 0, 0);
    add_row(iau_pkg::OP_SQUARE, -32'sh0003_0000, -32'sh0002_0000, '0, '0,
            0, '0, '0, 0, 0);
    // Sqrt clamps non-positive bounds to zero.
    add_row(iau_pkg::OP_SQRT, -32'sh0004_0000, 32'sh0004_0000, '0, '0,
            1, '0, 32'sh0002_0000, 0, 0);
    add_row(iau_pkg::OP_SQRT, 32'sh0000_0002, iau_pkg::DATA_MAX, '0, '0, 0, '0, '0, 0, 0);
    // Divisor containing zero, including a malformed divisor with a zero bound.
    add_row(iau_pkg::OP_DIV, 32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000, 32'sh0001_0000,
            1, iau_pkg::DATA_MIN, iau_pkg::DATA_MAX, 1, 0);
    add_row(iau_pkg::OP_DIV, 32'sh0001_0000, 32'sh0002_0000, '0, -32'sh0005_0000,
            1, iau_pkg::DATA_MIN, iau_pkg::DATA_MAX, 1, 0);
    // Saturation at both ends of the range.
    add_row(iau_pkg::OP_ADD, iau_pkg::DATA_MAX, iau_pkg::DATA_MAX, iau_pkg::DATA_MAX,
            iau_pkg::DATA_MAX, 1, iau_pkg::DATA_MAX, iau_pkg::DATA_MAX, 0, 1);
    add_row(iau_pkg::OP_SUB, iau_pkg::DATA_MIN, iau_pkg::DATA_MIN, iau_pkg::DATA_MAX,
            iau_pkg::DATA_MAX, 1, iau_pkg::DATA_MIN, iau_pkg::DATA_MIN, 0, 1);
    add_row(iau_pkg::OP_NEG, iau_pkg::DATA_MIN, iau_pkg::DATA_MIN, '0, '0,
            1, iau_pkg::DATA_MAX, iau_pkg::DATA_MAX, 0, 1);
    add_row(iau_pkg::OP_MUL, iau_pkg::DATA_MIN, iau_pkg::DATA_MAX, iau_pkg::DATA_MIN,
            iau_pkg::DATA_MAX, 1, iau_pkg::DATA_MIN, iau_pkg::DATA_MAX, 0, 1);
    add_row(iau_pkg::OP_DIV, iau_pkg::DATA_MIN, iau_pkg::DATA_MAX, 32'sh0000_0001,
            32'sh0000_0001, 1, iau_pkg::DATA_MIN, iau_pkg::DATA_MAX, 0, 1);
    // A reversed interval runs through the same formulas.
    add_row(iau_pkg::OP_MUL, 32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000,
            -32'sh0004_0000, 0, '0, '0, 0, 0);
    // Unused modes return an all-zero result.
    add_row(iau_pkg::OP_NONE, iau_pkg::DATA_MAX, iau_pkg::DATA_MIN, iau_pkg::DATA_MAX,
            iau_pkg::DATA_MIN, 1, '0, '0, 0, 0);
    add_row(MODE_TOP, iau_pkg::DATA_MIN, iau_pkg::DATA_MAX, iau_pkg::DATA_MIN,
            iau_pkg::DATA_MAX, 1, '0, '0, 0, 0);

    // Random part: mostly ordered intervals and real operations.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      it.mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 9));
      it.al = rand_bound();
      it.au = rand_bound();
      it.bl = rand_bound();
      it.bu = rand_bound();
      if ($urandom_range(0, 4) != 0) begin
        if (it.al > it.au) begin
          t = it.al;
          it.al = it.au;
          it.au = t;
        end
        if (it.bl > it.bu) begin
          t = it.bl;
          it.bl = it.bu;
          it.bu = t;
        end
      end
      it.typed = 0;
      it.want = '{default: '0};
      stim_list.push_back(it);
    end
  end

  // Cycle loop: drive requests, check responses, then drain.
  initial begin
    int pos;
    int cycles;
    int drain;
    int phase;
    int send_idle;
    int recv_stall;
    iv_item_t it;
    iv_result_t want;
    pos = 0;
    cycles = 0;
    drain = 0;
    req_ch.valid <= 1'b0;
    req_ch.mode <= '0;
    req_ch.a_lower <= '0;
    req_ch.a_upper <= '0;
    req_ch.b_lower <= '0;
    req_ch.b_upper <= '0;
    rsp_ch.ready <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 pending_results.size());
        $display("FAIL interval_arithmetic_unit");
        $finish;
      end

      // Compare an accepted result with the oldest expectation.
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, lower", rsp_ch.res_lower, 0);
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.res_lower !== want.lo) report_mismatch("res_lower", rsp_ch.res_lower, want.lo);
          if (rsp_ch.res_upper !== want.hi) report_mismatch("res_upper", rsp_ch.res_upper, want.hi);
          if (rsp_ch.unbounded !== want.unb)
            report_mismatch("unbounded", rsp_ch.unbounded, want.unb);
          if (rsp_ch.saturated !== want.sat)
            report_mismatch("saturated", rsp_ch.saturated, want.sat);
        end
        result_count++;
      end

      // Record the expectation of an accepted request item.
      if (req_ch.valid && req_ch.ready) begin
        it = stim_list[pos];
        pending_results.push_back(it.typed ? it.want : predict_interval(it));
        mode_hits[it.mode]++;
        pos++;
      end

      // Idle pattern follows the quarter of the stimulus being sent.
      phase = (pos * 4) / stim_list.size();
      send_idle = (phase == 1) ? 56 : (phase == 3) ? 23 : 0;
      recv_stall = (phase == 2) ? 56 : (phase == 3) ? 23 : 0;
      if (pos >= stim_list.size()) recv_stall = 0;

      if (!req_ch.valid || req_ch.ready) begin
        if (pos < stim_list.size() && $urandom_range(0, 99) >= send_idle) begin
          it = stim_list[pos];
          req_ch.valid <= 1'b1;
          req_ch.mode <= it.mode;
          req_ch.a_lower <= it.al;
          req_ch.a_upper <= it.au;
          req_ch.b_lower <= it.bl;
          req_ch.b_upper <= it.bu;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall);

      // After the last item, wait out the pipeline for stray results.
      if (pos >= stim_list.size() && pending_results.size() == 0) begin
        drain++;
        if (drain > DRAIN_CYC) break;
      end
    end

    $display("covered %0d items (%0d directed) and %0d results across four idle patterns",
             pos, stim_list.size() - NUM_RANDOM, result_count);
    $display("items per mode add..sqrt: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4],
             mode_hits[5], mode_hits[6], mode_hits[7], mode_hits[8], mode_hits[9]);
    if (error_count == 0) begin
      $display("PASS interval_arithmetic_unit");
    end else begin
      $display("FAIL interval_arithmetic_unit");
    end
    $finish;
  end

endmodule
